// ===== rtl/vertex_euler_rotate_project_defines.svh =====
// Assertion macros shared by the vertex rotate and project RTL.
`ifndef VERTEX_EULER_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_EULER_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, disabled while dis is true.
`define VEP_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is true.
`define VEP_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vep_pkg.sv =====
// Shared constants, types and sine lookup for the vertex rotate and project block.
`timescale 1ns / 1ps

package vep_pkg;

  localparam int SINE_ENTRIES = 64;
  localparam int IDX_W        = $clog2(SINE_ENTRIES);
  localparam int ANGLE_W      = IDX_W + 2;
  localparam int SIN_W        = 9;
  localparam int FRAC_BITS    = 8;
  localparam int COORD_W      = 8;
  localparam int SCALE_W      = 4;
  localparam int CENTER_W     = 10;
  localparam int SCREEN_W     = 12;
  localparam int DEPTH_W      = 10;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 10;

  localparam logic [ANGLE_W-1:0]  ANGLE_RESET  = '0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 4'd3;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd60;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ANGLE_X  = 3'd0,
    CFG_ANGLE_Y  = 3'd1,
    CFG_ANGLE_Z  = 3'd2,
    CFG_SCALE    = 3'd3,
    CFG_CENTER_X = 3'd4,
    CFG_CENTER_Y = 3'd5
  } cfg_index_t;

  typedef logic signed [SIN_W-1:0] trig_val_t;

  // Registered view of the configuration as the datapath uses it.
  typedef struct packed {
    trig_val_t             sin_x;
    trig_val_t             cos_x;
    trig_val_t             sin_y;
    trig_val_t             cos_y;
    trig_val_t             sin_z;
    trig_val_t             cos_z;
    logic [SCALE_W-1:0]    scale;
    logic [CENTER_W-1:0]   center_x;
    logic [CENTER_W-1:0]   center_y;
  } trig_t;

  // Quarter wave, amplitude 255 (Q8).
  localparam logic [7:0] QUARTER_WAVE [SINE_ENTRIES] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255
  };

  // Fold the binary angle onto the quarter wave: mirror in the second half of
  // each half turn, negate in the second half turn, zero on the axes.
  function automatic trig_val_t wave_sin(input logic [ANGLE_W-1:0] a);
    logic [IDX_W-1:0] idx;
    trig_val_t        mag;
    idx = a[IDX_W] ? ~a[IDX_W-1:0] : a[IDX_W-1:0];
    mag = {1'b0, QUARTER_WAVE[idx]};
    if (a[IDX_W:0] == '0) begin
      return '0;
    end
    return a[IDX_W+1] ? -mag : mag;
  endfunction

  function automatic trig_val_t wave_cos(input logic [ANGLE_W-1:0] a);
    return wave_sin(a + ANGLE_W'(SINE_ENTRIES));
  endfunction

endpackage

// ===== rtl/vep_cfg_regs.sv =====
// Configuration registers and registered sine/cosine of the three angles.
`timescale 1ns / 1ps

module vep_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vep_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vep_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output vep_pkg::trig_t                   trig
);
  import vep_pkg::*;

  logic [ANGLE_W-1:0]  angle_x_r, angle_x_nxt;
  logic [ANGLE_W-1:0]  angle_y_r, angle_y_nxt;
  logic [ANGLE_W-1:0]  angle_z_r, angle_z_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic [CENTER_W-1:0] center_x_r, center_x_nxt;
  logic [CENTER_W-1:0] center_y_r, center_y_nxt;
  trig_t               trig_r, trig_nxt;

  always_comb begin
    angle_x_nxt  = angle_x_r;
    angle_y_nxt  = angle_y_r;
    angle_z_nxt  = angle_z_r;
    scale_nxt    = scale_r;
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_X:  angle_x_nxt  = cfg_wdata[ANGLE_W-1:0];
        CFG_ANGLE_Y:  angle_y_nxt  = cfg_wdata[ANGLE_W-1:0];
        CFG_ANGLE_Z:  angle_z_nxt  = cfg_wdata[ANGLE_W-1:0];
        CFG_SCALE:    scale_nxt    = cfg_wdata[SCALE_W-1:0];
        CFG_CENTER_X: center_x_nxt = cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y: center_y_nxt = cfg_wdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trig_nxt.sin_x    = wave_sin(angle_x_r);
    trig_nxt.cos_x    = wave_cos(angle_x_r);
    trig_nxt.sin_y    = wave_sin(angle_y_r);
    trig_nxt.cos_y    = wave_cos(angle_y_r);
    trig_nxt.sin_z    = wave_sin(angle_z_r);
    trig_nxt.cos_z    = wave_cos(angle_z_r);
    trig_nxt.scale    = scale_r;
    trig_nxt.center_x = center_x_r;
    trig_nxt.center_y = center_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r  <= ANGLE_RESET;
      angle_y_r  <= ANGLE_RESET;
      angle_z_r  <= ANGLE_RESET;
      scale_r    <= SCALE_RESET;
      center_x_r <= CENTER_RESET;
      center_y_r <= CENTER_RESET;
    end else begin
      angle_x_r  <= angle_x_nxt;
      angle_y_r  <= angle_y_nxt;
      angle_z_r  <= angle_z_nxt;
      scale_r    <= scale_nxt;
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  // Lookup result is refreshed every cycle; no reset needed.
  always_ff @(posedge clk) begin
    trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

// ===== rtl/vep_rot_stage.sv =====
// One plane rotation stage: p = (a*cos - b*sin) >>> 8, q = (a*sin + b*cos) >>> 8.
`timescale 1ns / 1ps
`include "vertex_euler_rotate_project_defines.svh"

module vep_rot_stage #(
  parameter int A_W    = 8,
  parameter int B_W    = 8,
  parameter int OUT_W  = 9,
  parameter int PASS_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  input  vep_pkg::trig_val_t      sin_v,
  input  vep_pkg::trig_val_t      cos_v,
  input  logic [PASS_W-1:0]       pass_in,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] p,
  output logic signed [OUT_W-1:0] q,
  output logic [PASS_W-1:0]       pass_out
);
  import vep_pkg::*;

  localparam int PROD_W = ((A_W > B_W) ? A_W : B_W) + SIN_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [SUM_W-1:0] a_ext, b_ext, s_ext, c_ext;
  logic signed [SUM_W-1:0] p_sum, q_sum, p_shr, q_shr;
  logic signed [OUT_W-1:0] p_nxt, q_nxt;
  logic                    valid_r;
  logic signed [OUT_W-1:0] p_r, q_r;
  logic [PASS_W-1:0]       pass_r;

  always_comb begin
    a_ext = SUM_W'(a);
    b_ext = SUM_W'(b);
    s_ext = SUM_W'(sin_v);
    c_ext = SUM_W'(cos_v);
    p_sum = a_ext * c_ext - b_ext * s_ext;
    q_sum = a_ext * s_ext + b_ext * c_ext;
    p_shr = p_sum >>> FRAC_BITS;
    q_shr = q_sum >>> FRAC_BITS;
    p_nxt = p_shr[OUT_W-1:0];
    q_nxt = q_shr[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    pass_r <= pass_in;
  end

  assign out_valid = valid_r;
  assign p         = p_r;
  assign q         = q_r;
  assign pass_out  = pass_r;

  // The shifted sums must fit the stage output without loss.
  `VEP_ASSERT_IMP(a_p_fits, clk, !rst_n, in_valid, p_shr == SUM_W'(p_nxt), "p overflows stage")
  `VEP_ASSERT_IMP(a_q_fits, clk, !rst_n, in_valid, q_shr == SUM_W'(q_nxt), "q overflows stage")

endmodule

// ===== rtl/vep_project.sv =====
// Screen projection: scale, offset and saturate x/y, saturate depth; output register.
`timescale 1ns / 1ps

module vep_project #(
  parameter int X_W = 11,
  parameter int Y_W = 10,
  parameter int Z_W = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [X_W-1:0]             px,
  input  logic signed [Y_W-1:0]             py,
  input  logic signed [Z_W-1:0]             pz,
  input  logic                              in_last,
  input  vep_pkg::trig_t                    trig,
  output logic                              out_valid,
  output logic signed [vep_pkg::SCREEN_W-1:0] screen_x,
  output logic signed [vep_pkg::SCREEN_W-1:0] screen_y,
  output logic signed [vep_pkg::DEPTH_W-1:0]  depth_z,
  output logic                              out_last
);
  import vep_pkg::*;

  localparam int XY_W = (X_W > Y_W) ? X_W : Y_W;
  localparam int PJ_W = ((XY_W + SCALE_W + 1 > CENTER_W + 1) ?
                         XY_W + SCALE_W + 1 : CENTER_W + 1) + 1;
  localparam logic signed [PJ_W-1:0] SCR_MAX = PJ_W'(2 ** (SCREEN_W - 1) - 1);
  localparam logic signed [PJ_W-1:0] SCR_MIN = -PJ_W'(2 ** (SCREEN_W - 1));
  localparam logic signed [Z_W-1:0]  DEP_MAX = Z_W'(2 ** (DEPTH_W - 1) - 1);
  localparam logic signed [Z_W-1:0]  DEP_MIN = -Z_W'(2 ** (DEPTH_W - 1));

  logic signed [PJ_W-1:0]     scale_ext, cx_ext, cy_ext, sx_sum, sy_sum;
  logic signed [SCREEN_W-1:0] sx_nxt, sy_nxt;
  logic signed [DEPTH_W-1:0]  dz_nxt;
  logic                       valid_r;
  logic signed [SCREEN_W-1:0] sx_r, sy_r;
  logic signed [DEPTH_W-1:0]  dz_r;
  logic                       last_r;

  always_comb begin
    scale_ext = PJ_W'({1'b0, trig.scale});
    cx_ext    = PJ_W'({1'b0, trig.center_x});
    cy_ext    = PJ_W'({1'b0, trig.center_y});
    sx_sum    = PJ_W'(px) * scale_ext + cx_ext;
    sy_sum    = PJ_W'(py) * scale_ext + cy_ext;
    if (sx_sum > SCR_MAX) begin
      sx_nxt = SCR_MAX[SCREEN_W-1:0];
    end else if (sx_sum < SCR_MIN) begin
      sx_nxt = SCR_MIN[SCREEN_W-1:0];
    end else begin
      sx_nxt = sx_sum[SCREEN_W-1:0];
    end
    if (sy_sum > SCR_MAX) begin
      sy_nxt = SCR_MAX[SCREEN_W-1:0];
    end else if (sy_sum < SCR_MIN) begin
      sy_nxt = SCR_MIN[SCREEN_W-1:0];
    end else begin
      sy_nxt = sy_sum[SCREEN_W-1:0];
    end
    if (pz > DEP_MAX) begin
      dz_nxt = DEP_MAX[DEPTH_W-1:0];
    end else if (pz < DEP_MIN) begin
      dz_nxt = DEP_MIN[DEPTH_W-1:0];
    end else begin
      dz_nxt = pz[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    dz_r   <= dz_nxt;
    last_r <= in_last;
  end

  assign out_valid = valid_r;
  assign screen_x  = sx_r;
  assign screen_y  = sy_r;
  assign depth_z   = dz_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/vertex_euler_rotate_project.sv =====
// Top level: vertex rotation about X, Z, Y and projection to screen coordinates.
// Pipeline: a vertex accepted into the input register passes three rotation
//   stages and the projection register before its result strobe.
// Throughput: one vertex per clock, sustained; busy never rises after reset.
// Reset (rst_n low, synchronous): empties the pipeline, loads the register
//   defaults, and holds busy high through reset and the cycle after it.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "vertex_euler_rotate_project_defines.svh"

module vertex_euler_rotate_project (
  input  logic                                clk,
  input  logic                                rst_n,
  // Vertex input beat
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vep_pkg::COORD_W-1:0]  in_model_x,
  input  logic signed [vep_pkg::COORD_W-1:0]  in_model_y,
  input  logic signed [vep_pkg::COORD_W-1:0]  in_model_z,
  input  logic                                in_vertex_last,
  // Result beat
  output logic                                out_valid,
  output logic signed [vep_pkg::SCREEN_W-1:0] out_screen_x,
  output logic signed [vep_pkg::SCREEN_W-1:0] out_screen_y,
  output logic signed [vep_pkg::DEPTH_W-1:0]  out_depth_z,
  output logic                                out_last,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [vep_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [vep_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import vep_pkg::*;

  // Coordinate widths after each rotation. X rotation keeps |y|,|z| <= 255;
  // Z rotation grows x,y to |v| <= 383; Y rotation grows x,z to |v| <= 639.
  localparam int R1_W = COORD_W + 1;
  localparam int R2_W = R1_W + 1;
  localparam int R3_W = R2_W + 1;

  trig_t                     trig;
  logic                      busy_r;
  logic                      in_fire;

  // Input register
  logic                      s0_valid_r;
  logic signed [COORD_W-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic                      s0_last_r;

  // After rotation about X: y1, z1; x and last ride along
  logic                      s1_valid;
  logic signed [R1_W-1:0]    s1_y, s1_z;
  logic [COORD_W:0]          s1_pass;
  logic signed [COORD_W-1:0] s1_x;
  logic                      s1_last;

  // After rotation about Z: x2, y2; z1 and last ride along
  logic                      s2_valid;
  logic signed [R2_W-1:0]    s2_x, s2_y;
  logic [R1_W:0]             s2_pass;
  logic signed [R1_W-1:0]    s2_z;
  logic                      s2_last;

  // After rotation about Y: x3, z3; y2 and last ride along
  logic                      s3_valid;
  logic signed [R3_W-1:0]    s3_x, s3_z;
  logic [R2_W:0]             s3_pass;
  logic signed [R2_W-1:0]    s3_y;
  logic                      s3_last;

  // Accept whenever start is high and busy is low; the pipeline never stalls.
  assign in_fire = start && !busy_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s0_valid_r <= in_fire;
    end
  end

  // Capture the vertex beat; payload needs no reset.
  always_ff @(posedge clk) begin
    s0_x_r    <= in_model_x;
    s0_y_r    <= in_model_y;
    s0_z_r    <= in_model_z;
    s0_last_r <= in_vertex_last;
  end

  // Registers plus sine/cosine lookup, refreshed every cycle.
  vep_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .trig      (trig)
  );

  // Rotate about X: y' = y*cx - z*sx, z' = y*sx + z*cx
  vep_rot_stage #(
    .A_W    (COORD_W),
    .B_W    (COORD_W),
    .OUT_W  (R1_W),
    .PASS_W (COORD_W + 1)
  ) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .a         (s0_y_r),
    .b         (s0_z_r),
    .sin_v     (trig.sin_x),
    .cos_v     (trig.cos_x),
    .pass_in   ({s0_x_r, s0_last_r}),
    .out_valid (s1_valid),
    .p         (s1_y),
    .q         (s1_z),
    .pass_out  (s1_pass)
  );

  assign s1_x    = s1_pass[COORD_W:1];
  assign s1_last = s1_pass[0];

  // Rotate about Z: x' = x*cz - y*sz, y' = x*sz + y*cz
  vep_rot_stage #(
    .A_W    (COORD_W),
    .B_W    (R1_W),
    .OUT_W  (R2_W),
    .PASS_W (R1_W + 1)
  ) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .a         (s1_x),
    .b         (s1_y),
    .sin_v     (trig.sin_z),
    .cos_v     (trig.cos_z),
    .pass_in   ({s1_z, s1_last}),
    .out_valid (s2_valid),
    .p         (s2_x),
    .q         (s2_y),
    .pass_out  (s2_pass)
  );

  assign s2_z    = s2_pass[R1_W:1];
  assign s2_last = s2_pass[0];

  // Rotate about Y: x' = x*cy - z*sy, z' = x*sy + z*cy
  vep_rot_stage #(
    .A_W    (R2_W),
    .B_W    (R1_W),
    .OUT_W  (R3_W),
    .PASS_W (R2_W + 1)
  ) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .a         (s2_x),
    .b         (s2_z),
    .sin_v     (trig.sin_y),
    .cos_v     (trig.cos_y),
    .pass_in   ({s2_y, s2_last}),
    .out_valid (s3_valid),
    .p         (s3_x),
    .q         (s3_z),
    .pass_out  (s3_pass)
  );

  assign s3_y    = s3_pass[R2_W:1];
  assign s3_last = s3_pass[0];

  // Scale, offset and saturate; this is the output register.
  vep_project #(
    .X_W (R3_W),
    .Y_W (R2_W),
    .Z_W (R3_W)
  ) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .px        (s3_x),
    .py        (s3_y),
    .pz        (s3_z),
    .in_last   (s3_last),
    .trig      (trig),
    .out_valid (out_valid),
    .screen_x  (out_screen_x),
    .screen_y  (out_screen_y),
    .depth_z   (out_depth_z),
    .out_last  (out_last)
  );

  // Every accepted beat comes out after the rotation stages and the projection register.
  `VEP_ASSERT_IMP(a_latency, clk, !rst_n, in_fire, ##5 out_valid, "result beat missing")
  // Reset empties the pipeline.
  `VEP_ASSERT_NEXT(a_reset_flush, clk, 1'b0, !rst_n, !out_valid && busy, "pipeline not flushed")
  // Nothing leaves while the block is still coming out of reset.
  `VEP_ASSERT_IMP(a_busy_quiet, clk, !rst_n, busy, !out_valid && !s3_valid, "beat during busy")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the vertex rotate and project pipeline.
`timescale 1ns / 1ps

module tb;
  import vep_pkg::*;

  // Pipeline depth from accept edge to result edge, plus margin for the
  // registered trig view that follows a register write.
  localparam int PIPE_LATENCY = 5;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_VERTICES = 1350;

  // Indexes past the six registers; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  // One projected vertex as the result port shows it.
  typedef struct {
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic signed [DEPTH_W-1:0]  depth_z;
    logic                       last;
  } screen_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        start = 1'b0;
  logic                        busy;
  logic signed [COORD_W-1:0]   in_model_x = '0;
  logic signed [COORD_W-1:0]   in_model_y = '0;
  logic signed [COORD_W-1:0]   in_model_z = '0;
  logic                        in_vertex_last = 1'b0;
  logic                        out_valid;
  logic signed [SCREEN_W-1:0]  out_screen_x;
  logic signed [SCREEN_W-1:0]  out_screen_y;
  logic signed [DEPTH_W-1:0]   out_depth_z;
  logic                        out_last;
  logic                        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  // Shadow copy of the register file, updated on every write we issue.
  logic [ANGLE_W-1:0]  rot_x = ANGLE_RESET;
  logic [ANGLE_W-1:0]  rot_y = ANGLE_RESET;
  logic [ANGLE_W-1:0]  rot_z = ANGLE_RESET;
  logic [SCALE_W-1:0]  pix_scale = SCALE_RESET;
  logic [CENTER_W-1:0] origin_x = CENTER_RESET;
  logic [CENTER_W-1:0] origin_y = CENTER_RESET;

  screen_point_t pending_points[$];
  screen_point_t want;

  int          errors = 0;
  int          vertices_sent = 0;
  int          results_checked = 0;
  int          settings_used = 0;
  int          clamped_coords = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  vertex_euler_rotate_project u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_model_x     (in_model_x),
    .in_model_y     (in_model_y),
    .in_model_z     (in_model_z),
    .in_vertex_last (in_vertex_last),
    .out_valid      (out_valid),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_depth_z    (out_depth_z),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sine of a binary angle from the quarter-wave table: zero on the axes,
  // mirror the index in the second quarter of each half turn, negate in the
  // second half turn. Cosine is the same lookup a quarter turn ahead.
  function automatic int wave_lookup(input logic [ANGLE_W-1:0] a);
    logic [IDX_W-1:0] idx;
    int               mag;
    if (a[IDX_W:0] == '0) begin
      return 0;
    end
    idx = a[IDX_W] ? IDX_W'(SINE_ENTRIES - 1) - a[IDX_W-1:0] : a[IDX_W-1:0];
    mag = QUARTER_WAVE[idx];
    return a[IDX_W+1] ? -mag : mag;
  endfunction

  function automatic int saturate(input int v, input int lo, input int hi);
    if (v < lo) begin
      clamped_coords++;
      return lo;
    end
    if (v > hi) begin
      clamped_coords++;
      return hi;
    end
    return v;
  endfunction

  // Rotate about X, then Z, then Y with floor shifts after each stage, then
  // scale, offset and saturate to the screen. >>> on int floors, as the hardware does.
  function automatic screen_point_t project_vertex(input logic signed [COORD_W-1:0] mx,
                                                   input logic signed [COORD_W-1:0] my,
                                                   input logic signed [COORD_W-1:0] mz,
                                                   input logic lst);
    int            sin_a, cos_a, sin_b, cos_b, sin_c, cos_c;
    int            x, y, z, nx, ny, nz;
    screen_point_t p;
    sin_a = wave_lookup(rot_x);
    cos_a = wave_lookup(rot_x + ANGLE_W'(SINE_ENTRIES));
    sin_b = wave_lookup(rot_y);
    cos_b = wave_lookup(rot_y + ANGLE_W'(SINE_ENTRIES));
    sin_c = wave_lookup(rot_z);
    cos_c = wave_lookup(rot_z + ANGLE_W'(SINE_ENTRIES));
    x = mx;
    y = my;
    z = mz;
    ny = (y * cos_a - z * sin_a) >>> FRAC_BITS;
    nz = (y * sin_a + z * cos_a) >>> FRAC_BITS;
    y = ny;
    z = nz;
    nx = (x * cos_c - y * sin_c) >>> FRAC_BITS;
    ny = (x * sin_c + y * cos_c) >>> FRAC_BITS;
    x = nx;
    y = ny;
    nx = (x * cos_b - z * sin_b) >>> FRAC_BITS;
    nz = (x * sin_b + z * cos_b) >>> FRAC_BITS;
    p.screen_x = SCREEN_W'(saturate(nx * int'(pix_scale) + int'(origin_x), -2048, 2047));
    p.screen_y = SCREEN_W'(saturate(ny * int'(pix_scale) + int'(origin_y), -2048, 2047));
    p.depth_z  = DEPTH_W'(saturate(nz, -512, 511));
    p.last     = lst;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending vertex.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, got x=%0d y=%0d z=%0d last=%0b",
                 $time, out_screen_x, out_screen_y, out_depth_z, out_last);
      end else begin
        want = pending_points.pop_front();
        results_checked++;
        if (out_screen_x !== want.screen_x)
          report_mismatch("screen_x", int'(want.screen_x), int'(out_screen_x));
        if (out_screen_y !== want.screen_y)
          report_mismatch("screen_y", int'(want.screen_y), int'(out_screen_y));
        if (out_depth_z !== want.depth_z)
          report_mismatch("depth_z", int'(want.depth_z), int'(out_depth_z));
        if (out_last !== want.last)
          report_mismatch("last", int'(want.last), int'(out_last));
      end
    end
  end

  // Watchdog: end the run with an error once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: watchdog expired with %0d results pending", $time, pending_points.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hold start low for gap cycles, then present one beat and hold it until
  // an edge sees busy low. Leave start high so back-to-back beats stay
  // glitch free; the next idle cycle or the drain drops it.
  task automatic send_vertex(input logic signed [COORD_W-1:0] mx,
                             input logic signed [COORD_W-1:0] my,
                             input logic signed [COORD_W-1:0] mz,
                             input logic lst, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_model_x     <= mx;
    in_model_y     <= my;
    in_model_z     <= mz;
    in_vertex_last <= lst;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    pending_points.push_back(project_vertex(mx, my, mz, lst));
    vertices_sent++;
  endtask

  // Drop start and wait for the pipeline to empty out before touching
  // registers.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write beat; mirror it in the shadow copy with the same
  // width masking the hardware applies.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ANGLE_X:  rot_x     = data[ANGLE_W-1:0];
      CFG_ANGLE_Y:  rot_y     = data[ANGLE_W-1:0];
      CFG_ANGLE_Z:  rot_z     = data[ANGLE_W-1:0];
      CFG_SCALE:    pix_scale = data[SCALE_W-1:0];
      CFG_CENTER_X: origin_x  = data[CENTER_W-1:0];
      CFG_CENTER_Y: origin_y  = data[CENTER_W-1:0];
      default: ;
    endcase
  endtask

  // Load a full view. Stuff random junk into the bits above the angle and
  // scale widths so the masking gets exercised on those writes.
  task automatic set_view(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                          input logic [ANGLE_W-1:0] az, input logic [SCALE_W-1:0] sc,
                          input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
    logic [CFG_DATA_W-1:0] junk;
    drain_pipeline();
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ANGLE_X, {junk[CFG_DATA_W-1:ANGLE_W], ax});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ANGLE_Y, {junk[CFG_DATA_W-1:ANGLE_W], ay});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ANGLE_Z, {junk[CFG_DATA_W-1:ANGLE_W], az});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_SCALE, {junk[CFG_DATA_W-1:SCALE_W], sc});
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    settings_used++;
  endtask

  // A quarter of the time a coordinate is picked from -128, 127, 0 and -1.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return -8'sd128;
        1:       return 8'sd127;
        2:       return 8'sd0;
        default: return -8'sd1;
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults straight out of reset: no rotation, scale 3, center 60.
  task automatic test_reset_defaults();
    send_vertex(8'sd0, 8'sd0, 8'sd0, 1'b0, 0);
    send_vertex(8'sd127, 8'sd127, 8'sd127, 1'b1, 0);
    send_vertex(-8'sd128, -8'sd128, -8'sd128, 1'b0, 1);
    send_vertex(8'sd127, -8'sd128, 8'sd1, 1'b1, 0);
  endtask

  // Axis angles, both sides of each quarter boundary, and the wraparound
  // at the top of the angle range.
  task automatic test_angle_folding();
    set_view(8'd64, 8'd192, 8'd128, 4'd3, 10'd512, 10'd512);
    send_vertex(8'sd100, -8'sd77, 8'sd33, 1'b0, 0);
    send_vertex(-8'sd128, 8'sd127, -8'sd128, 1'b1, 0);
    set_view(8'd63, 8'd65, 8'd127, 4'd2, 10'd300, 10'd700);
    send_vertex(8'sd127, 8'sd127, -8'sd128, 1'b0, 0);
    send_vertex(-8'sd5, 8'sd90, 8'sd45, 1'b1, 2);
    set_view(8'd129, 8'd191, 8'd193, 4'd4, 10'd400, 10'd400);
    send_vertex(8'sd64, 8'sd64, 8'sd64, 1'b0, 0);
    send_vertex(-8'sd1, -8'sd1, -8'sd1, 1'b1, 0);
    set_view(8'd255, 8'd1, 8'd0, 4'd1, 10'd100, 10'd900);
    send_vertex(8'sd127, -8'sd128, 8'sd127, 1'b0, 0);
    send_vertex(-8'sd128, 8'sd127, -8'sd128, 1'b1, 0);
  endtask

  // Bits above a register's width are dropped; indexes past the last
  // register must leave everything alone.
  task automatic test_register_masking();
    drain_pipeline();
    write_reg(CFG_ANGLE_X, 10'h3C0);
    write_reg(CFG_SCALE, 10'h3F5);
    send_vertex(8'sd50, -8'sd60, 8'sd70, 1'b0, 0);
    drain_pipeline();
    write_reg(CFG_SPARE_LO, 10'h3FF);
    write_reg(CFG_SPARE_HI, 10'h3FF);
    send_vertex(8'sd50, -8'sd60, 8'sd70, 1'b1, 0);
  endtask

  // Push the projection past both ends of the 12-bit screen range, and
  // collapse it to the center with a zero scale.
  task automatic test_screen_saturation();
    set_view(8'd32, 8'd32, 8'd32, 4'd15, 10'd1023, 10'd1023);
    send_vertex(8'sd127, 8'sd127, 8'sd127, 1'b0, 0);
    send_vertex(-8'sd128, -8'sd128, -8'sd128, 1'b1, 0);
    set_view(8'd160, 8'd224, 8'd96, 4'd15, 10'd0, 10'd0);
    send_vertex(-8'sd128, -8'sd128, -8'sd128, 1'b0, 0);
    send_vertex(8'sd127, 8'sd127, 8'sd127, 1'b1, 0);
    set_view(8'd255, 8'd255, 8'd255, 4'd0, 10'd1023, 10'd0);
    send_vertex(8'sd127, -8'sd128, 8'sd127, 1'b1, 0);
  endtask

  // Phases of random vertices, each under a fresh view. Some phases pin the
  // registers to their extremes. Gaps come in stretches: some run back to
  // back, others draw a random idle count per beat.
  task automatic test_random_stream();
    int   phase_len;
    int   stretch_left;
    bit   no_idle;
    int   gap;
    int   kind;
    stretch_left = 0;
    no_idle      = 1'b0;
    while (vertices_sent < RANDOM_VERTICES + 19) begin
      kind = $urandom_range(0, 5);
      if (kind == 0)
        set_view(8'd0, 8'd0, 8'd0, 4'd0, 10'd0, 10'd0);
      else if (kind == 1)
        set_view(8'd255, 8'd255, 8'd255, 4'd15, 10'd1023, 10'd1023);
      else
        set_view(ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom),
                 SCALE_W'($urandom), CENTER_W'($urandom), CENTER_W'($urandom));
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(4, 24);
          no_idle      = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        // Now and then hold off until every pending result is back.
        if ($urandom_range(0, 63) == 0) drain_pipeline();
        send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), gap);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_angle_folding();
    test_register_masking();
    test_screen_saturation();
    test_random_stream();

    drain_pipeline();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Projected %0d vertices under %0d register views; %0d results compared.",
             vertices_sent, settings_used, results_checked);
    $display("Saturated %0d coordinates; %0d mismatches.", clamped_coords, errors);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
